// ===== hw/rtl/letr_pkg.sv =====
`timescale 1ns / 1ps

package letr_pkg;

    // Default sizes of the transition table
    localparam int ENTRIES_DEF    = 16;
    localparam int DATA_WIDTH_DEF = 8;

    // Fixed field widths of the request and result ports
    localparam int OPCODE_W = 3;
    localparam int FIELD_W  = 8;
    localparam int PAGE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Reset values
    localparam logic [PAGE_W-1:0]  PAGE_RESET   = 8'd1;
    localparam logic [FIELD_W-1:0] SAMPLE_RESET = 8'hFF;

    // Request opcodes
    localparam logic [OPCODE_W-1:0] OP_STEP      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_LEARN     = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_CLEAR_ALL = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_SET_STATE = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CREATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;
    localparam logic [STATUS_W-1:0] ST_WAS_EMPTY = 3'd7;

    // Commands from the sequencer to the table store
    typedef struct packed {
        logic rd;     // read one entry, data registered
        logic wr;     // write one entry and mark it occupied
        logic inval;  // free one entry
        logic clr;    // free every entry
    } t_store_ctl;

endpackage

// ===== hw/rtl/letr_store.sv =====
`timescale 1ns / 1ps

module letr_store #(
    parameter int ENTRIES    = letr_pkg::ENTRIES_DEF,
    parameter int DATA_WIDTH = letr_pkg::DATA_WIDTH_DEF,
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  letr_pkg::t_store_ctl        i_ctl,
    input  logic [AW-1:0]               i_rd_addr,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [letr_pkg::PAGE_W-1:0] i_wr_page,
    input  logic [DATA_WIDTH-1:0]       i_wr_key,
    input  logic [DATA_WIDTH-1:0]       i_wr_from,
    input  logic [DATA_WIDTH-1:0]       i_wr_next,
    output logic                        o_rd_valid,
    output logic [letr_pkg::PAGE_W-1:0] o_rd_page,
    output logic [DATA_WIDTH-1:0]       o_rd_key,
    output logic [DATA_WIDTH-1:0]       o_rd_from,
    output logic [DATA_WIDTH-1:0]       o_rd_next,
    output logic [CW-1:0]               o_count
);
    import letr_pkg::*;

    logic [PAGE_W-1:0]     r_page_mem [ENTRIES];
    logic [DATA_WIDTH-1:0] r_key_mem  [ENTRIES];
    logic [DATA_WIDTH-1:0] r_from_mem [ENTRIES];
    logic [DATA_WIDTH-1:0] r_next_mem [ENTRIES];

    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] n_valid;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;

    // Write one entry of the table memory
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_page_mem[i_wr_addr] <= i_wr_page;
            r_key_mem[i_wr_addr]  <= i_wr_key;
            r_from_mem[i_wr_addr] <= i_wr_from;
            r_next_mem[i_wr_addr] <= i_wr_next;
        end
    end

    // Read one entry, register the data and its occupied bit
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            o_rd_page  <= r_page_mem[i_rd_addr];
            o_rd_key   <= r_key_mem[i_rd_addr];
            o_rd_from  <= r_from_mem[i_rd_addr];
            o_rd_next  <= r_next_mem[i_rd_addr];
            o_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // Track occupied entries and their number
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        if (i_ctl.clr) begin
            n_valid = '0;
            n_count = '0;
        end else if (i_ctl.wr) begin
            n_valid[i_wr_addr] = 1'b1;
            n_count            = r_count + CW'(1);
        end else if (i_ctl.inval) begin
            n_valid[i_wr_addr] = 1'b0;
            n_count            = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    assign o_count = r_count;

endmodule

// ===== hw/rtl/letr_seq.sv =====
`timescale 1ns / 1ps

module letr_seq #(
    parameter int ENTRIES    = letr_pkg::ENTRIES_DEF,
    parameter int DATA_WIDTH = letr_pkg::DATA_WIDTH_DEF,
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [letr_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [letr_pkg::FIELD_W-1:0]  i_pattern,
    input  logic [letr_pkg::FIELD_W-1:0]  i_value,
    input  logic [letr_pkg::PAGE_W-1:0]   i_active_page,
    input  logic [CW-1:0]                 i_count,
    input  logic                          i_rd_valid,
    input  logic [letr_pkg::PAGE_W-1:0]   i_rd_page,
    input  logic [DATA_WIDTH-1:0]         i_rd_key,
    input  logic [DATA_WIDTH-1:0]         i_rd_from,
    input  logic [DATA_WIDTH-1:0]         i_rd_next,
    output letr_pkg::t_store_ctl          o_ctl,
    output logic [AW-1:0]                 o_rd_addr,
    output logic [AW-1:0]                 o_wr_addr,
    output logic [letr_pkg::PAGE_W-1:0]   o_wr_page,
    output logic [DATA_WIDTH-1:0]         o_wr_key,
    output logic [DATA_WIDTH-1:0]         o_wr_from,
    output logic [DATA_WIDTH-1:0]         o_wr_next,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [DATA_WIDTH-1:0]         o_state,
    output logic [letr_pkg::STATUS_W-1:0] o_status
);
    import letr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_SCAN   = 2'd2;
    localparam logic [1:0] S_RESP   = 2'd3;

    logic [1:0]            r_fsm,       n_fsm;
    logic [OPCODE_W-1:0]   r_op,        n_op;
    logic [DATA_WIDTH-1:0] r_pat,       n_pat;
    logic [DATA_WIDTH-1:0] r_val,       n_val;
    logic [DATA_WIDTH-1:0] r_key,       n_key;
    logic [DATA_WIDTH-1:0] r_state,     n_state;
    logic [DATA_WIDTH-1:0] r_prev,      n_prev;
    logic [STATUS_W-1:0]   r_status,    n_status;
    logic [CW-1:0]         r_idx,       n_idx;
    logic                  r_pend,      n_pend;
    logic [AW-1:0]         r_pidx,      n_pidx;
    logic                  r_empty_ok,  n_empty_ok;
    logic [AW-1:0]         r_empty_idx, n_empty_idx;

    logic w_issue;
    logic w_hit;

    // Shared compare unit: entry read last cycle against page, key and state
    assign w_hit = i_rd_valid && (i_rd_page == i_active_page) &&
                   (i_rd_key == r_key) && (i_rd_from == r_state);

    // Sequence one request: decode, scan the table where the opcode needs it, then report
    always_comb begin
        n_fsm       = r_fsm;
        n_op        = r_op;
        n_pat       = r_pat;
        n_val       = r_val;
        n_key       = r_key;
        n_state     = r_state;
        n_prev      = r_prev;
        n_status    = r_status;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_empty_ok  = r_empty_ok;
        n_empty_idx = r_empty_idx;
        o_ctl       = '0;
        o_wr_addr   = r_empty_idx;
        w_issue     = 1'b0;

        unique case (r_fsm)
            S_IDLE: begin
                if (i_start) begin
                    n_op  = i_opcode;
                    n_pat = DATA_WIDTH'(i_pattern);
                    n_val = DATA_WIDTH'(i_value);
                    n_fsm = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status    = ST_DONE;
                n_fsm       = S_RESP;
                n_idx       = '0;
                n_pend      = 1'b0;
                n_empty_ok  = 1'b0;
                n_empty_idx = '0;
                unique case (r_op)
                    OP_STEP: begin
                        if (r_prev != r_pat) begin
                            n_key  = (r_prev ^ r_pat) & r_pat;
                            n_prev = r_pat;
                            n_fsm  = S_SCAN;
                        end
                    end
                    OP_LEARN: begin
                        if (i_active_page == '0) begin
                            n_status = ST_FULL;
                        end else begin
                            n_key = r_pat;
                            n_fsm = S_SCAN;
                        end
                    end
                    OP_REMOVE: begin
                        n_key = r_pat;
                        n_fsm = S_SCAN;
                    end
                    OP_CLEAR_ALL: begin
                        o_ctl.clr = 1'b1;
                        n_status  = (i_count != '0) ? ST_CLEARED : ST_WAS_EMPTY;
                    end
                    OP_SET_STATE: begin
                        n_state = r_val;
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                // Issue the next read while comparing the previous one
                w_issue   = (r_idx < CW'(ENTRIES));
                o_ctl.rd  = w_issue;
                n_pend    = w_issue;
                n_pidx    = r_idx[AW-1:0];
                if (w_issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_pend && w_hit) begin
                    n_fsm = S_RESP;
                    unique case (r_op)
                        OP_STEP: begin
                            n_state  = i_rd_next;
                            n_status = ST_DONE;
                        end
                        OP_LEARN: begin
                            n_status = ST_EXISTS;
                        end
                        OP_REMOVE: begin
                            o_ctl.inval = 1'b1;
                            o_wr_addr   = r_pidx;
                            n_status    = ST_REMOVED;
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    // Remember the lowest free entry for a learn
                    if (r_pend && !i_rd_valid && !r_empty_ok) begin
                        n_empty_ok  = 1'b1;
                        n_empty_idx = r_pidx;
                    end
                    // Finish a scan that found no match
                    if (!w_issue && !r_pend) begin
                        n_fsm = S_RESP;
                        unique case (r_op)
                            OP_STEP: begin
                                n_status = ST_DONE;
                            end
                            OP_LEARN: begin
                                if (r_empty_ok) begin
                                    o_ctl.wr  = 1'b1;
                                    o_wr_addr = r_empty_idx;
                                    n_status  = ST_CREATED;
                                end else begin
                                    n_status = ST_FULL;
                                end
                            end
                            OP_REMOVE: begin
                                n_status = ST_NOT_FOUND;
                            end
                            default: begin
                                n_status = ST_DONE;
                            end
                        endcase
                    end
                end
            end
            S_RESP: begin
                n_fsm = S_IDLE;
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // Hold control state and machine state under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm   <= S_IDLE;
            r_state <= '0;
            r_prev  <= DATA_WIDTH'(SAMPLE_RESET);
            r_pend  <= 1'b0;
        end else begin
            r_fsm   <= n_fsm;
            r_state <= n_state;
            r_prev  <= n_prev;
            r_pend  <= n_pend;
        end
    end

    // Advance the request payload and scan bookkeeping
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_pat       <= n_pat;
        r_val       <= n_val;
        r_key       <= n_key;
        r_status    <= n_status;
        r_idx       <= n_idx;
        r_pidx      <= n_pidx;
        r_empty_ok  <= n_empty_ok;
        r_empty_idx <= n_empty_idx;
    end

    assign o_rd_addr = r_idx[AW-1:0];
    assign o_wr_page = i_active_page;
    assign o_wr_key  = r_key;
    assign o_wr_from = r_state;
    assign o_wr_next = r_val;
    assign o_busy    = (r_fsm != S_IDLE);
    assign o_done    = (r_fsm == S_RESP);
    assign o_state   = r_state;
    assign o_status  = r_status;

endmodule

// ===== hw/rtl/learnable_edge_transition_table.sv =====
`timescale 1ns / 1ps

// Programmable edge-driven state machine with a learnable transition table.
// A request is taken when start is high and busy is low; busy then stays high
// until its single result has been shown. The result sits on o_current_state,
// o_status and o_entry_count for exactly one cycle with o_done high and must be
// captured then, as the block cannot be held off. set_state, clear_all, an
// unchanged step sample, a learn with page zero and an unknown opcode go from
// decode straight to the result; step, learn and remove scan the table one
// entry per cycle through a single read port and one shared comparator, a
// match ending the scan early. A new request is accepted in the cycle after
// o_done. The table's occupied bits are cleared by reset at once, so no
// clearing pass is needed. active_page must be written through i_cfg_we /
// i_cfg_data only while no request is in flight; the block does not enforce it.

module learnable_edge_transition_table #(
    parameter int ENTRIES    = letr_pkg::ENTRIES_DEF,
    parameter int DATA_WIDTH = letr_pkg::DATA_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [letr_pkg::PAGE_W-1:0]   i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic [letr_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [letr_pkg::FIELD_W-1:0]  i_pattern,
    input  logic [letr_pkg::FIELD_W-1:0]  i_value,
    output logic                          o_done,
    output logic [letr_pkg::FIELD_W-1:0]  o_current_state,
    output logic [letr_pkg::STATUS_W-1:0] o_status,
    output logic [letr_pkg::COUNT_W-1:0]  o_entry_count
);
    import letr_pkg::*;

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic [PAGE_W-1:0]     r_active_page;
    t_store_ctl            w_ctl;
    logic [AW-1:0]         w_rd_addr;
    logic [AW-1:0]         w_wr_addr;
    logic [PAGE_W-1:0]     w_wr_page;
    logic [DATA_WIDTH-1:0] w_wr_key;
    logic [DATA_WIDTH-1:0] w_wr_from;
    logic [DATA_WIDTH-1:0] w_wr_next;
    logic                  w_rd_valid;
    logic [PAGE_W-1:0]     w_rd_page;
    logic [DATA_WIDTH-1:0] w_rd_key;
    logic [DATA_WIDTH-1:0] w_rd_from;
    logic [DATA_WIDTH-1:0] w_rd_next;
    logic [CW-1:0]         w_count;
    logic [DATA_WIDTH-1:0] w_state;

    // Hold the active page register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_page <= PAGE_RESET;
        end else if (i_cfg_we) begin
            r_active_page <= i_cfg_data;
        end
    end

    letr_seq #(
        .ENTRIES    (ENTRIES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_opcode      (i_opcode),
        .i_pattern     (i_pattern),
        .i_value       (i_value),
        .i_active_page (r_active_page),
        .i_count       (w_count),
        .i_rd_valid    (w_rd_valid),
        .i_rd_page     (w_rd_page),
        .i_rd_key      (w_rd_key),
        .i_rd_from     (w_rd_from),
        .i_rd_next     (w_rd_next),
        .o_ctl         (w_ctl),
        .o_rd_addr     (w_rd_addr),
        .o_wr_addr     (w_wr_addr),
        .o_wr_page     (w_wr_page),
        .o_wr_key      (w_wr_key),
        .o_wr_from     (w_wr_from),
        .o_wr_next     (w_wr_next),
        .o_busy        (busy),
        .o_done        (o_done),
        .o_state       (w_state),
        .o_status      (o_status)
    );

    letr_store #(
        .ENTRIES    (ENTRIES),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_rd_addr  (w_rd_addr),
        .i_wr_addr  (w_wr_addr),
        .i_wr_page  (w_wr_page),
        .i_wr_key   (w_wr_key),
        .i_wr_from  (w_wr_from),
        .i_wr_next  (w_wr_next),
        .o_rd_valid (w_rd_valid),
        .o_rd_page  (w_rd_page),
        .o_rd_key   (w_rd_key),
        .o_rd_from  (w_rd_from),
        .o_rd_next  (w_rd_next),
        .o_count    (w_count)
    );

    // Fit state and count to the result fields
    assign o_current_state = FIELD_W'(w_state);
    assign o_entry_count   = COUNT_W'(w_count);

    // A taken request keeps the block busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // The result strobe lasts one cycle and frees the block
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe not followed by idle");

    // The result is only shown while a request is in flight
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // The occupied count never exceeds the table size
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(ENTRIES))
        else $error("entry count above table size");

endmodule

// ===== tb/letr_result_checker.sv =====
`timescale 1ns / 1ps

module letr_result_checker #(
    parameter int ENTRIES = letr_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [letr_pkg::PAGE_W-1:0]   i_cfg_data,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [letr_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [letr_pkg::FIELD_W-1:0]  i_pattern,
    input  logic [letr_pkg::FIELD_W-1:0]  i_value,
    input  logic                          i_done,
    input  logic [letr_pkg::FIELD_W-1:0]  i_current_state,
    input  logic [letr_pkg::STATUS_W-1:0] i_status,
    input  logic [letr_pkg::COUNT_W-1:0]  i_entry_count,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked,
    output logic [7:0]                    o_status_seen
);
    import letr_pkg::*;

    typedef struct packed {
        logic [FIELD_W-1:0]  state;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } t_result;

    // Shadow copy of the transition table and machine
    logic [PAGE_W-1:0]  page_reg;
    logic [PAGE_W-1:0]  slot_page [ENTRIES];
    logic [FIELD_W-1:0] slot_key  [ENTRIES];
    logic [FIELD_W-1:0] slot_from [ENTRIES];
    logic [FIELD_W-1:0] slot_next [ENTRIES];
    logic [FIELD_W-1:0] fsm_state;
    logic [FIELD_W-1:0] last_sample;

    t_result    expected_results [$];
    int         mismatches    = 0;
    int         pending_count = 0;
    int         checked_count = 0;
    logic [7:0] status_hits   = '0;

    assign o_fail_count  = mismatches;
    assign o_pending     = pending_count;
    assign o_checked     = checked_count;
    assign o_status_seen = status_hits;

    // Lowest occupied slot on the active page matching key and current state
    function automatic int find_transition(input logic [FIELD_W-1:0] key);
        int hit;
        hit = -1;
        if (page_reg != '0) begin
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (slot_page[i] == page_reg && slot_key[i] == key &&
                    slot_from[i] == fsm_state) begin
                    hit = i;
                end
            end
        end
        return hit;
    endfunction

    function automatic logic [COUNT_W-1:0] occupied_count();
        int n;
        n = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot_page[i] != '0) n++;
        end
        return COUNT_W'(n);
    endfunction

    // Apply one request to the shadow table and form its result
    task automatic predict_transition(input logic [OPCODE_W-1:0] op,
                                      input logic [FIELD_W-1:0] pat,
                                      input logic [FIELD_W-1:0] val,
                                      output t_result res);
        int                  slot;
        logic [FIELD_W-1:0]  rise;
        logic [STATUS_W-1:0] st;
        bit                  placed;
        st = ST_DONE;
        placed = 1'b0;
        case (op)
            OP_STEP: begin
                if (last_sample != pat) begin
                    rise = (last_sample ^ pat) & pat;
                    slot = find_transition(rise);
                    if (slot >= 0) fsm_state = slot_next[slot];
                    last_sample = pat;
                end
            end
            OP_LEARN: begin
                if (page_reg == '0) begin
                    st = ST_FULL;
                end else if (find_transition(pat) >= 0) begin
                    st = ST_EXISTS;
                end else begin
                    st = ST_FULL;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!placed && slot_page[i] == '0) begin
                            slot_page[i] = page_reg;
                            slot_key[i]  = pat;
                            slot_from[i] = fsm_state;
                            slot_next[i] = val;
                            placed = 1'b1;
                            st = ST_CREATED;
                        end
                    end
                end
            end
            OP_REMOVE: begin
                slot = find_transition(pat);
                if (slot >= 0) begin
                    slot_page[slot] = '0;
                    st = ST_REMOVED;
                end else begin
                    st = ST_NOT_FOUND;
                end
            end
            OP_CLEAR_ALL: begin
                st = (occupied_count() != '0) ? ST_CLEARED : ST_WAS_EMPTY;
                for (int i = 0; i < ENTRIES; i++) slot_page[i] = '0;
            end
            OP_SET_STATE: begin
                fsm_state = val;
            end
            default: begin
            end
        endcase
        res.state  = fsm_state;
        res.status = st;
        res.count  = occupied_count();
    endtask

    // Watch config writes, requests and results at each rising edge
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            page_reg    = PAGE_RESET;
            fsm_state   = '0;
            last_sample = SAMPLE_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                slot_page[i] = '0;
                slot_key[i]  = '0;
                slot_from[i] = '0;
                slot_next[i] = '0;
            end
            expected_results.delete();
            pending_count = 0;
        end else begin
            // Compare a shown result against the oldest expectation
            if (i_done) begin
                got = {i_current_state, i_status, i_entry_count};
                if (expected_results.size() == 0) begin
                    $error("result with no request outstanding: state %0h status %0d count %0d",
                           got.state, got.status, got.count);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    checked_count++;
                    status_hits[want.status] = 1'b1;
                    if (got.state !== want.state) begin
                        $error("current_state: expected %0h, actual %0h",
                               want.state, got.state);
                        mismatches++;
                    end
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.count !== want.count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.count, got.count);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) page_reg = i_cfg_data;
            // Predict each accepted request
            if (i_start && !i_busy) begin
                predict_transition(i_opcode, i_pattern, i_value, want);
                expected_results.push_back(want);
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== tb/tb_learnable_edge_transition_table.sv =====
`timescale 1ns / 1ps

module tb_learnable_edge_transition_table;
    import letr_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [PAGE_W-1:0]   i_cfg_data;
    logic                start;
    logic                busy;
    logic [OPCODE_W-1:0] i_opcode;
    logic [FIELD_W-1:0]  i_pattern;
    logic [FIELD_W-1:0]  i_value;
    logic                o_done;
    logic [FIELD_W-1:0]  o_current_state;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0]  o_entry_count;

    int         fail_count;
    int         pending;
    int         checked;
    logic [7:0] status_seen;
    int         sent_count = 0;
    int         page_writes = 0;
    bit         quiet = 1'b0;

    always #1 i_clk = ~i_clk;

    learnable_edge_transition_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_pattern      (i_pattern),
        .i_value        (i_value),
        .o_done         (o_done),
        .o_current_state(o_current_state),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count)
    );

    letr_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_start        (start),
        .i_busy         (busy),
        .i_opcode       (i_opcode),
        .i_pattern      (i_pattern),
        .i_value        (i_value),
        .i_done         (o_done),
        .i_current_state(o_current_state),
        .i_status       (o_status),
        .i_entry_count  (o_entry_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_status_seen  (status_seen)
    );

    // Mostly short gaps, a few long ones, none at all in quiet stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Small key pool so that learned transitions get hit by steps
    function automatic logic [FIELD_W-1:0] pick_key();
        case ($urandom_range(0, 8))
            0: return 8'h01;
            1: return 8'h02;
            2: return 8'h04;
            3: return 8'h08;
            4: return 8'h03;
            5: return 8'h80;
            6: return 8'hFF;
            7: return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] pick_state();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'h01;
            2: return 8'h02;
            3: return 8'h03;
            4: return 8'h04;
            5: return 8'h05;
            6: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Present one request, hold it until taken, then idle for a random gap
    task automatic send_req(input logic [OPCODE_W-1:0] op,
                            input logic [FIELD_W-1:0] pat,
                            input logic [FIELD_W-1:0] val);
        int gap;
        start     = 1'b1;
        i_opcode  = op;
        i_pattern = pat;
        i_value   = val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Drop start and hold off until every expected result has come
    task automatic drain();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_page(input logic [PAGE_W-1:0] page);
        drain();
        i_cfg_we   = 1'b1;
        i_cfg_data = page;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        page_writes++;
    endtask

    // One page setting with a mix of edge sequences, table edits and noise
    task automatic run_phase(input logic [PAGE_W-1:0] page, input int n, input bit clear_ok);
        int                  count;
        int                  r;
        logic [OPCODE_W-1:0] op;
        count = 0;
        write_page(page);
        while (count < n) begin
            if (count % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (count == n / 2) drain();
            r = $urandom_range(0, 99);
            if (r < 30) begin
                send_req(OP_STEP,
                         ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h00,
                         8'($urandom_range(0, 255)));
                send_req(OP_STEP, pick_key(), 8'($urandom_range(0, 255)));
                count += 2;
            end else begin
                if (r < 65) begin
                    send_req(OP_LEARN, pick_key(), pick_state());
                end else if (r < 73) begin
                    send_req(OP_REMOVE, pick_key(), 8'($urandom_range(0, 255)));
                end else if (r < 80) begin
                    send_req(OP_SET_STATE, 8'($urandom_range(0, 255)), pick_state());
                end else if (r < 81 && clear_ok) begin
                    send_req(OP_CLEAR_ALL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end else if (r < 85) begin
                    send_req(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                end else begin
                    op = 3'($urandom_range(0, 7));
                    if (op == OP_CLEAR_ALL && (!clear_ok || $urandom_range(0, 1) == 0)) begin
                        op = OP_STEP;
                    end
                    send_req(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
                count++;
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        start      = 1'b0;
        i_opcode   = OP_STEP;
        i_pattern  = '0;
        i_value    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty table, create/exists, edge lookups, remove, bad opcodes
        write_page(PAGE_RESET);
        send_req(OP_STEP, SAMPLE_RESET, 8'h00);
        send_req(OP_STEP, 8'h00, 8'hFF);
        send_req(OP_REMOVE, 8'h05, 8'h00);
        send_req(OP_CLEAR_ALL, 8'h00, 8'h00);
        send_req(OP_LEARN, 8'h01, 8'h10);
        send_req(OP_LEARN, 8'h01, 8'h20);
        send_req(OP_STEP, 8'h01, 8'h00);
        send_req(OP_STEP, 8'h01, 8'h00);
        send_req(OP_SET_STATE, 8'h00, 8'hFF);
        send_req(OP_LEARN, 8'hFF, 8'h00);
        send_req(OP_STEP, 8'h00, 8'h00);
        send_req(OP_STEP, 8'hFF, 8'h00);
        send_req(OP_STEP, 8'h7F, 8'h00);
        send_req(OP_LEARN, 8'h80, 8'hAA);
        send_req(OP_REMOVE, 8'h80, 8'h00);
        send_req(OP_REMOVE, 8'h80, 8'h00);
        send_req(3'd5, 8'hFF, 8'hFF);
        send_req(3'd6, 8'h00, 8'h00);
        send_req(3'd7, 8'hA5, 8'h5A);
        send_req(OP_SET_STATE, 8'hFF, 8'h00);
        send_req(OP_CLEAR_ALL, 8'hFF, 8'hFF);

        // Page zero: nothing matches and learns report full
        write_page(8'd0);
        send_req(OP_LEARN, 8'h01, 8'h01);
        send_req(OP_STEP, 8'h01, 8'h00);
        send_req(OP_REMOVE, 8'h01, 8'h00);

        // Random phases over several page settings
        run_phase(8'd1, 300, 1'b0);
        run_phase(8'd2, 250, 1'b1);
        run_phase(8'd255, 300, 1'b0);
        run_phase(8'd0, 60, 1'b1);
        run_phase(8'($urandom_range(3, 254)), 250, 1'b1);
        run_phase(8'd1, 300, 1'b1);
        run_phase(8'd128, 290, 1'b0);

        drain();
        repeat (24) @(posedge i_clk);
        $display("Checked %0d results from %0d requests over %0d active_page settings.",
                 checked, sent_count, page_writes);
        $display("Status codes reached: %0d of 8 (mask %b).", $countones(status_seen),
                 status_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
